// File: hw/rtl/sdh_pkg.sv
// shared constants, codes and types of the site dedup hash set
package sdh_pkg;

  // bucket count must be a power of two: the bucket is the low bits of the hash
  localparam int BUCKETS     = 4096;
  localparam int NODES       = 16384;
  localparam int BUCKET_BITS = $clog2(BUCKETS);
  localparam int NODE_BITS   = $clog2(NODES);
  localparam int CNT_BITS    = $clog2(NODES + 1);
  localparam int POS_BITS    = 31;
  localparam int STRAND_BITS = 8;
  localparam int KEY_BITS    = POS_BITS + STRAND_BITS;
  localparam int UCOUNT_BITS = 15;

  localparam logic [31:0] MIX_MUL = 32'h045d9f3b;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NEW     = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_FINISH,
    S_INIT
  } state_t;

  // one node of the pool: key, owning bucket and link to the next node
  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [BUCKET_BITS-1:0] bucket;
    logic                   link_valid;
    logic [NODE_BITS-1:0]   link;
  } node_t;

  // result of the hash pipeline
  typedef struct packed {
    logic                   done;
    logic [BUCKET_BITS-1:0] bucket;
  } hash_res_t;

endpackage

// File: hw/rtl/sdh_ram.sv
// generic single-write, single-read ram with registered read data
module sdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/sdh_hash.sv
// four-stage hash pipeline from (position, strand) to bucket index
module sdh_hash (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sdh_pkg::POS_BITS-1:0]      position,
  input  logic [sdh_pkg::STRAND_BITS-1:0]   strand,
  output sdh_pkg::hash_res_t                res
);

  logic [31:0] pos_w;
  logic [31:0] seed;
  logic [31:0] h0;
  logic [31:0] h1;
  logic [31:0] h2;
  logic [31:0] x0;
  logic [31:0] x1;
  logic [31:0] x2;
  logic [2:0]  vld;
  logic        done;
  logic [sdh_pkg::BUCKET_BITS-1:0] bucket;

  // pos*31 as shift and subtract
  assign pos_w = {1'b0, position};
  assign seed  = (pos_w << 5) - pos_w + {24'd0, strand};
  assign x0    = h0 ^ (h0 >> 16);
  assign x1    = h1 ^ (h1 >> 16);
  assign x2    = h2 ^ (h2 >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[1:0], start};
      done <= vld[2];
    end
    if (start) begin
      h0 <= seed;
    end
    h1     <= x0 * sdh_pkg::MIX_MUL;
    h2     <= x1 * sdh_pkg::MIX_MUL;
    bucket <= x2[sdh_pkg::BUCKET_BITS-1:0];
  end

  assign res.done   = done;
  assign res.bucket = bucket;

endmodule

// File: hw/rtl/site_dedup_hash_set.sv
// top level of the site dedup hash set: sequencer, head and node memories
// Deduplicating set of (position, strand) keys held as a chained hash table.
// An insert answers new, duplicate or pool full; a clear answers cleared and
// empties the set at once, with no sweep of the memories. Each beat in gives
// exactly one beat out, with the unique count after that item. A clear goes
// straight to the result; an insert hashes the key, reads the bucket head
// and, if the head is live, walks the chain. The timing of an insert is set
// by the four-stage hash pipeline, the registered read of the bucket head
// memory and the single read port of the node memory, which follows the
// chain one node a cycle. One item is worked on at a time; the next input
// beat is taken as soon as the result has moved into the output register,
// even if it is not yet taken. Bucket heads are trusted only when they
// point below the fill count to a node that records the same bucket, so a
// clear does not have to touch the memories; only the fill count is zeroed.
// After reset the head memory is swept to zero once, one bucket a cycle, and
// no input beat is taken until the sweep is done.
module site_dedup_hash_set (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [sdh_pkg::POS_BITS-1:0]      position,
  input  logic [sdh_pkg::STRAND_BITS-1:0]   strand,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [sdh_pkg::UCOUNT_BITS-1:0]   unique_count
);

  sdh_pkg::state_t  state;
  sdh_pkg::state_t  state_next;

  // item context
  logic [sdh_pkg::KEY_BITS-1:0]    key_reg;
  logic                            cmd_clear;
  logic [sdh_pkg::BUCKET_BITS-1:0] bucket_reg;
  logic [sdh_pkg::NODE_BITS-1:0]   head_idx_reg;
  logic                            head_ok;
  logic                            first;
  logic                            found;
  logic [sdh_pkg::CNT_BITS-1:0]    count;

  // head sweep after reset
  logic [sdh_pkg::BUCKET_BITS-1:0] init_addr;
  logic                            init_last;

  // memory ports
  logic                            head_we;
  logic                            head_re;
  logic [sdh_pkg::BUCKET_BITS-1:0] head_waddr;
  logic [sdh_pkg::NODE_BITS-1:0]   head_wdata;
  logic [sdh_pkg::NODE_BITS-1:0]   head_rdata;
  logic                            node_we;
  logic                            node_re;
  logic [sdh_pkg::NODE_BITS-1:0]   node_raddr;
  sdh_pkg::node_t                  node_wdata;
  sdh_pkg::node_t                  node_rdata;

  // decisions
  logic                            in_fire;
  logic                            hash_start;
  sdh_pkg::hash_res_t              hres;
  logic                            head_in_pool;
  logic                            bucket_hit;
  logic                            key_hit;
  logic                            pool_full;
  logic                            fin_fire;
  logic                            do_insert;
  sdh_pkg::status_t                status_next;

  assign in_ready   = (state == sdh_pkg::S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign hash_start = in_fire && (command == sdh_pkg::CMD_INSERT);
  assign init_last  = init_addr == sdh_pkg::BUCKET_BITS'(sdh_pkg::BUCKETS - 1);

  sdh_hash u_hash (
    .clk      (clk),
    .rst      (rst),
    .start    (hash_start),
    .position (position),
    .strand   (strand),
    .res      (hres)
  );

  // bucket heads: index of the newest node of each bucket
  sdh_ram #(
    .WIDTH (sdh_pkg::NODE_BITS),
    .DEPTH (sdh_pkg::BUCKETS)
  ) u_heads (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (hres.bucket),
    .rdata (head_rdata)
  );

  // node pool: key, bucket tag and chain link per node
  sdh_ram #(
    .WIDTH ($bits(sdh_pkg::node_t)),
    .DEPTH (sdh_pkg::NODES)
  ) u_nodes (
    .clk   (clk),
    .we    (node_we),
    .waddr (count[sdh_pkg::NODE_BITS-1:0]),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // a head counts only if it points at a node written since the last clear
  assign head_in_pool = sdh_pkg::CNT_BITS'(head_rdata) < count;
  // the first node read must also belong to this bucket, or the head is stale
  assign bucket_hit   = !first || (node_rdata.bucket == bucket_reg);
  assign key_hit      = node_rdata.key == key_reg;
  assign pool_full    = count >= sdh_pkg::CNT_BITS'(sdh_pkg::NODES);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sdh_pkg::S_INIT: begin
        if (init_last) begin
          state_next = sdh_pkg::S_IDLE;
        end
      end
      sdh_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = (command == sdh_pkg::CMD_CLEAR) ? sdh_pkg::S_FINISH
                                                       : sdh_pkg::S_HASH;
        end
      end
      sdh_pkg::S_HASH: begin
        if (hres.done) begin
          state_next = sdh_pkg::S_HEAD;
        end
      end
      sdh_pkg::S_HEAD: begin
        state_next = head_in_pool ? sdh_pkg::S_WALK : sdh_pkg::S_FINISH;
      end
      sdh_pkg::S_WALK: begin
        if (!bucket_hit || key_hit || !node_rdata.link_valid) begin
          state_next = sdh_pkg::S_FINISH;
        end
      end
      sdh_pkg::S_FINISH: begin
        if (fin_fire) begin
          state_next = sdh_pkg::S_IDLE;
        end
      end
      default: state_next = sdh_pkg::S_IDLE;
    endcase
  end

  // memory control and result
  always_comb begin
    head_re    = (state == sdh_pkg::S_HASH) && hres.done;
    node_re    = 1'b0;
    node_raddr = node_rdata.link;
    fin_fire   = (state == sdh_pkg::S_FINISH) && (!out_valid || out_ready);
    do_insert  = !cmd_clear && !found && !pool_full;
    head_we    = fin_fire && do_insert;
    head_waddr = bucket_reg;
    head_wdata = count[sdh_pkg::NODE_BITS-1:0];
    node_we    = fin_fire && do_insert;
    unique case (state)
      sdh_pkg::S_INIT: begin
        // zero one bucket head a cycle
        head_we    = 1'b1;
        head_waddr = init_addr;
        head_wdata = '0;
      end
      sdh_pkg::S_HEAD: begin
        node_re    = head_in_pool;
        node_raddr = head_rdata;
      end
      sdh_pkg::S_WALK: begin
        // follow the link while this node is ours and not the key
        node_re = bucket_hit && !key_hit && node_rdata.link_valid;
      end
      default: begin
      end
    endcase
    if (cmd_clear) begin
      status_next = sdh_pkg::ST_CLEARED;
    end else if (found) begin
      status_next = sdh_pkg::ST_DUP;
    end else if (pool_full) begin
      status_next = sdh_pkg::ST_FULL;
    end else begin
      status_next = sdh_pkg::ST_NEW;
    end
    // new node goes to the chain head, linked to the old head if it was live
    node_wdata.key        = key_reg;
    node_wdata.bucket     = bucket_reg;
    node_wdata.link_valid = head_ok;
    node_wdata.link       = head_idx_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdh_pkg::S_INIT;
      init_addr <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sdh_pkg::S_INIT) begin
        init_addr <= init_addr + 1'b1;
      end
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fin_fire) begin
        if (cmd_clear) begin
          count <= '0;
        end else if (do_insert) begin
          count <= count + 1'b1;
        end
      end
    end

    if (in_fire) begin
      key_reg   <= {strand, position};
      cmd_clear <= (command == sdh_pkg::CMD_CLEAR);
      found     <= 1'b0;
      head_ok   <= 1'b0;
    end
    if (head_re) begin
      bucket_reg <= hres.bucket;
    end
    if (state == sdh_pkg::S_HEAD) begin
      head_idx_reg <= head_rdata;
      first        <= 1'b1;
      head_ok      <= 1'b0;
    end
    if (state == sdh_pkg::S_WALK) begin
      first <= 1'b0;
      if (first) begin
        head_ok <= bucket_hit;
      end
      if (bucket_hit && key_hit) begin
        found <= 1'b1;
      end
    end
    if (fin_fire) begin
      status       <= status_next;
      unique_count <= sdh_pkg::UCOUNT_BITS'(cmd_clear ? '0 :
                                            (do_insert ? count + 1'b1 : count));
    end
  end

`ifndef ASSERT_OFF
  // the fill count never passes the pool size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sdh_pkg::CNT_BITS'(sdh_pkg::NODES))
    else $error("fill count beyond pool size");

  // a new node is only written while the pool has room
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    node_we |-> (head_we && !pool_full && !found))
    else $error("node written without room or on a duplicate");

  // every insert reported as new moves the count up by one
  a_new_counts: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && status_next == sdh_pkg::ST_NEW) |=> (count == $past(count) + 1'b1))
    else $error("new key not counted");

  // the chain walk always looks at data read in the cycle before
  a_walk_read: assert property (@(posedge clk) disable iff (rst)
    (state == sdh_pkg::S_WALK) |-> $past(node_re))
    else $error("chain walk without a node read");

  // a clear beat goes straight to the result
  a_clear_path: assert property (@(posedge clk) disable iff (rst)
    (in_fire && command == sdh_pkg::CMD_CLEAR) |=> (state == sdh_pkg::S_FINISH))
    else $error("clear did not go to the result stage");
`endif

endmodule

// File: tb/tb_site_dedup_hash_set.sv
// self-checking testbench of the site dedup hash set: directed and random traffic
`timescale 1ns / 100ps

module tb_site_dedup_hash_set;
  import sdh_pkg::*;

  // cycles with no beat on either side before the run is called hung,
  // well above the head sweep after reset
  localparam int unsigned STALL_LIMIT = 20000;
  // result index at which the receiver stops taking beats for a long stretch
  localparam int unsigned HOLD_AT     = 120;
  localparam int unsigned HOLD_CYCLES = 400;
  // colliding key groups used to build real chains
  localparam int GROUPS      = 8;
  localparam int PER_GROUP   = 8;
  localparam int KEY_POOL    = GROUPS * PER_GROUP;
  localparam int RANDOM_ITEMS = 740;

  // one input beat as the driver offers it, plus the wait in front of it
  typedef struct {
    cmd_t                   op;
    logic [POS_BITS-1:0]    pos;
    logic [STRAND_BITS-1:0] strand;
    int unsigned            gap;
  } site_beat_t;

  // one output beat as the set should answer it
  typedef struct {
    status_t                status;
    logic [UCOUNT_BITS-1:0] count;
  } site_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic                   command   = 1'b0;
  logic [POS_BITS-1:0]    position  = '0;
  logic [STRAND_BITS-1:0] strand    = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [UCOUNT_BITS-1:0] unique_count;

  site_dedup_hash_set u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .position     (position),
    .strand       (strand),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .unique_count (unique_count)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // reset held from time zero, released on a falling edge
  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // mirror of the set: bucket heads, node pool and fill count
  // ---------------------------------------------------------------------------
  int unsigned         head_node [BUCKETS];
  bit                  head_ok   [BUCKETS];
  logic [KEY_BITS-1:0] node_key  [NODES];
  int unsigned         node_next [NODES];
  bit                  next_ok   [NODES];
  int unsigned         fill_count = 0;

  // tallies for the closing summary
  int unsigned n_new = 0, n_dup = 0, n_full = 0, n_clear = 0, longest_walk = 0;

  // bucket of a key: multiply-add, two xor-shift-multiply rounds, xor-shift
  function automatic logic [BUCKET_BITS-1:0] site_bucket(logic [POS_BITS-1:0] p,
                                                         logic [STRAND_BITS-1:0] s);
    logic [31:0] h;
    h = {1'b0, p} * 32'd31 + {24'd0, s};
    h = (h ^ (h >> 16)) * MIX_MUL;
    h = (h ^ (h >> 16)) * MIX_MUL;
    h = h ^ (h >> 16);
    return BUCKET_BITS'(h % BUCKETS);
  endfunction

  // apply one accepted beat to the mirror and return the answer it must give
  function automatic site_answer_t apply_site(logic op, logic [POS_BITS-1:0] p,
                                              logic [STRAND_BITS-1:0] s);
    site_answer_t        a;
    logic [KEY_BITS-1:0] key;
    int unsigned         b, idx, walk;
    bit                  have, hit;
    if (op == CMD_CLEAR) begin
      // clear only forgets the heads, like the block, so stale nodes stay stale
      foreach (head_ok[i]) head_ok[i] = 1'b0;
      fill_count = 0;
      a.status = ST_CLEARED;
      n_clear++;
    end else begin
      key  = {s, p};
      b    = site_bucket(p, s);
      have = head_ok[b];
      idx  = head_node[b];
      hit  = 1'b0;
      walk = 0;
      while (have && idx < NODES && walk < NODES && !hit) begin
        walk++;
        if (node_key[idx] == key) begin
          hit = 1'b1;
        end else begin
          have = next_ok[idx];
          idx  = node_next[idx];
        end
      end
      if (walk > longest_walk) longest_walk = walk;
      if (hit) begin
        a.status = ST_DUP;
        n_dup++;
      end else if (fill_count >= NODES) begin
        a.status = ST_FULL;
        n_full++;
      end else begin
        // new node goes to the head of its chain
        node_key[fill_count]  = key;
        node_next[fill_count] = head_node[b];
        next_ok[fill_count]   = head_ok[b];
        head_node[b] = fill_count;
        head_ok[b]   = 1'b1;
        fill_count++;
        a.status = ST_NEW;
        n_new++;
      end
    end
    a.count = UCOUNT_BITS'(fill_count);
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  site_beat_t   pending_q [$];
  site_answer_t answer_q [$];
  int unsigned  total_beats = 0;

  logic [POS_BITS-1:0]    pool_pos    [KEY_POOL];
  logic [STRAND_BITS-1:0] pool_strand [KEY_POOL];

  task automatic queue_site(cmd_t op, logic [POS_BITS-1:0] p, logic [STRAND_BITS-1:0] s,
                            int unsigned gap);
    site_beat_t t;
    t.op     = op;
    t.pos    = p;
    t.strand = s;
    t.gap    = gap;
    pending_q.push_back(t);
    total_beats++;
  endtask

  // wait in front of a beat: none inside quiet stretches, else 0..15
  function automatic int unsigned pick_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // strand codes lean toward '+' and '-' as in real data
  function automatic logic [STRAND_BITS-1:0] pick_strand();
    case ($urandom_range(0, 3))
      0:       return 8'd43;
      1:       return 8'd45;
      default: return STRAND_BITS'($urandom);
    endcase
  endfunction

  initial begin : gen_stimulus
    logic [BUCKET_BITS-1:0] target;
    logic [POS_BITS-1:0]    p;
    logic [STRAND_BITS-1:0] s;
    int unsigned            r, k;

    // key pool: groups of keys that all land in one bucket
    for (int g = 0; g < GROUPS; g++) begin
      target = BUCKET_BITS'($urandom);
      for (int j = 0; j < PER_GROUP; j++) begin
        do begin
          p = POS_BITS'($urandom);
          s = pick_strand();
        end while (site_bucket(p, s) != target);
        pool_pos[g*PER_GROUP + j]    = p;
        pool_strand[g*PER_GROUP + j] = s;
      end
    end

    // directed: empty clear, field extremes, duplicates, strand pairs
    queue_site(CMD_CLEAR,  '0, '0, pick_gap(0));
    queue_site(CMD_INSERT, '0, '0, pick_gap(0));
    queue_site(CMD_INSERT, '0, '0, pick_gap(0));
    queue_site(CMD_INSERT, '1, '1, pick_gap(0));
    queue_site(CMD_INSERT, '1, '0, pick_gap(1));
    queue_site(CMD_INSERT, '0, '1, pick_gap(1));
    queue_site(CMD_INSERT, 31'd1000, 8'd43, pick_gap(0));
    queue_site(CMD_INSERT, 31'd1000, 8'd45, pick_gap(0));
    queue_site(CMD_INSERT, 31'd1000, 8'd43, pick_gap(1));
    // three keys in one bucket, hit the tail and the head of that chain, then add a fourth
    for (int j = 0; j < 3; j++) queue_site(CMD_INSERT, pool_pos[j], pool_strand[j], pick_gap(1));
    queue_site(CMD_INSERT, pool_pos[0], pool_strand[0], pick_gap(0));
    queue_site(CMD_INSERT, pool_pos[2], pool_strand[2], pick_gap(0));
    queue_site(CMD_INSERT, pool_pos[3], pool_strand[3], pick_gap(0));
    // clear with non-zero key fields, which it ignores
    queue_site(CMD_CLEAR,  '1, '1, pick_gap(0));
    // keys from before the clear come back as new, stale chains not followed
    queue_site(CMD_INSERT, '0, '0, pick_gap(1));
    queue_site(CMD_INSERT, pool_pos[1], pool_strand[1], pick_gap(1));
    queue_site(CMD_INSERT, pool_pos[0], pool_strand[0], pick_gap(0));
    queue_site(CMD_CLEAR,  31'h2aaaaaaa, 8'h55, pick_gap(0));
    queue_site(CMD_CLEAR,  31'h55555555, 8'haa, pick_gap(1));
    queue_site(CMD_INSERT, pool_pos[4], pool_strand[4], pick_gap(0));

    // random: mostly pool keys so duplicates and chain walks dominate
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        queue_site(CMD_CLEAR, POS_BITS'($urandom), STRAND_BITS'($urandom),
                   pick_gap((i / 60) % 3 == 0));
      end else if (r < 18) begin
        queue_site(CMD_INSERT, POS_BITS'($urandom), STRAND_BITS'($urandom),
                   pick_gap((i / 60) % 3 == 0));
      end else begin
        k = $urandom_range(0, KEY_POOL - 1);
        queue_site(CMD_INSERT, pool_pos[k], pool_strand[k], pick_gap((i / 60) % 3 == 0));
      end
    end

    // short tail after a clear
    queue_site(CMD_CLEAR, '0, '0, pick_gap(0));
    for (int i = 0; i < 40; i++) begin
      k = $urandom_range(0, KEY_POOL - 1);
      queue_site(CMD_INSERT, pool_pos[k], pool_strand[k], pick_gap(0));
    end
  end

  // ---------------------------------------------------------------------------
  // handshake bookkeeping, prediction and checking at the rising edge
  // ---------------------------------------------------------------------------
  logic        in_beat  = 1'b0;
  logic        out_beat = 1'b0;
  int unsigned beats_in  = 0;
  int unsigned beats_out = 0;
  int unsigned fail_count = 0;

  always @(posedge clk) begin : scoreboard
    site_answer_t want;
    in_beat  <= in_valid && in_ready;
    out_beat <= out_valid && out_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (answer_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: status %0d count %0d", status, unique_count);
        end else begin
          want = answer_q.pop_front();
          if (status !== want.status || unique_count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected status %0d count %0d, got status %0d count %0d",
                       beats_out, want.status, want.count, status, unique_count);
          end
        end
      end
      // the answer leaves through a registered output, so a new beat never answers at this edge
      if (in_valid && in_ready) begin
        answer_q.push_back(apply_site(command, position, strand));
        beats_in++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender: offers queued beats on the falling edge after its drawn wait
  // ---------------------------------------------------------------------------
  site_beat_t  next_beat;
  bit          have_next = 1'b0;
  int unsigned gap_left  = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (!have_next && pending_q.size() > 0) begin
        next_beat = pending_q.pop_front();
        gap_left  = next_beat.gap;
        have_next = 1'b1;
      end
      if (have_next && gap_left == 0) begin
        // valid may stay high straight into the next beat
        in_valid  <= 1'b1;
        command   <= next_beat.op;
        position  <= next_beat.pos;
        strand    <= next_beat.strand;
        have_next = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (have_next) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: after each result beat waits a drawn number of cycles; once it
  // holds off long enough for the block to back up and stall its input
  // ---------------------------------------------------------------------------
  int unsigned taken     = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_beat) begin
        taken++;
        if (taken == HOLD_AT) hold_left = HOLD_CYCLES;
        else hold_left = pick_gap((taken / 40) % 3 == 2);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no beat on either side means the block is stuck
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("no beat for %0d cycles, %0d of %0d beats in, %0d results out",
               STALL_LIMIT, beats_in, total_beats, beats_out);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // end of run: all beats in, all answers back, then a short settle
  // ---------------------------------------------------------------------------
  initial begin : run_end
    wait (!rst);
    while (beats_in < total_beats || answer_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d beats: %0d new, %0d duplicate, %0d pool full, %0d clear",
             beats_in, n_new, n_dup, n_full, n_clear);
    $display("longest chain walk %0d nodes, %0d failures", longest_walk, fail_count);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sdh_pkg.sv
hw/rtl/sdh_ram.sv
hw/rtl/sdh_hash.sv
hw/rtl/site_dedup_hash_set.sv
tb/tb_site_dedup_hash_set.sv
